// ===== sv/rgb_channel_histogram_macros.svh =====
// Assertion macros shared by the histogram checker.
`ifndef RGB_CHANNEL_HISTOGRAM_MACROS_SVH
`define RGB_CHANNEL_HISTOGRAM_MACROS_SVH

// Implication checked in the next cycle, switched off while reset is high.
`define RGBH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgb histogram check failed");

// Implication checked in the next cycle, checked during reset as well.
`define RGBH_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rgb histogram check failed");

`endif

// ===== sv/rgbh_pkg.sv =====
// Types and constants shared by the RGB channel histogram files.
`default_nettype none

package rgbh_pkg;

  localparam int PIX_BITS       = 8;
  localparam int OUT_COUNT_BITS = 24;
  localparam int CHANNELS       = 3;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [PIX_BITS-1:0] red;
    logic [PIX_BITS-1:0] green;
    logic [PIX_BITS-1:0] blue;
    logic [PIX_BITS-1:0] bin_index;
  } req_t;

  typedef struct packed {
    logic [PIX_BITS-1:0]       bin_number;
    logic [OUT_COUNT_BITS-1:0] red_count;
    logic [OUT_COUNT_BITS-1:0] green_count;
    logic [OUT_COUNT_BITS-1:0] blue_count;
  } rsp_t;

endpackage

`default_nettype wire

// ===== sv/rgb_channel_histogram.sv =====
// A read word passes the update stage and then the result register, which offers its result word.
// Throughput: one word per cycle; a read word waits in the update stage while
// the result register is full and unread.
// Each channel's bins sit in a one-port-write, one-port-read memory updated by
// read-modify-write, with forwarding of the previous write.
// After reset a clearing pass zeroes every bin; no word is accepted during it.
`default_nettype none

module rgb_channel_histogram #(
  parameter int BIN_COUNT  = 256,
  parameter int COUNT_BITS = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire rgbh_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output rgbh_pkg::rsp_t     rsp
);

  localparam int AW = $clog2(BIN_COUNT);
  localparam int CH = rgbh_pkg::CHANNELS;

  function automatic logic [AW-1:0] bin_of(input logic [rgbh_pkg::PIX_BITS-1:0] v);
    logic [AW-1:0] a;
    if (32'(v) >= BIN_COUNT) begin
      a = AW'(BIN_COUNT - 1);
    end else begin
      a = AW'(v);
    end
    return a;
  endfunction

  logic                                   clearing;
  logic [AW-1:0]                          clear_addr;
  logic                                   s1_valid;
  logic                                   s1_op;
  logic                                   s1_in_range;
  logic [rgbh_pkg::PIX_BITS-1:0]          s1_bin;
  logic [CH-1:0][AW-1:0]                  s1_addr;
  logic                                   lw_valid;
  logic [CH-1:0][AW-1:0]                  lw_addr;
  logic [CH-1:0][COUNT_BITS-1:0]          lw_data;

  logic                                   accept;
  logic                                   s1_fire;
  logic                                   s1_we;
  logic                                   mem_we;
  logic                                   req_in_range;
  logic [CH-1:0][rgbh_pkg::PIX_BITS-1:0]  pix;
  logic [CH-1:0][AW-1:0]                  rd_addr;
  logic [CH-1:0][AW-1:0]                  wr_addr;
  logic [CH-1:0][COUNT_BITS-1:0]          wr_data;
  logic [CH-1:0][COUNT_BITS-1:0]          cur;
  logic [CH-1:0][COUNT_BITS-1:0]          s1_new;

  assign pix[0] = req.red;
  assign pix[1] = req.green;
  assign pix[2] = req.blue;

  assign req_in_range = 32'(req.bin_index) < BIN_COUNT;
  assign s1_fire = s1_valid && (s1_op == rgbh_pkg::OP_ADD || !rsp_valid || rsp_ready);
  assign req_ready = !clearing && (!s1_valid || s1_fire);
  assign accept = req_valid && req_ready;
  assign s1_we = s1_fire && (s1_op == rgbh_pkg::OP_ADD || s1_in_range);
  assign mem_we = clearing || s1_we;

  always_comb begin
    for (int c = 0; c < CH; c++) begin
      if (req.operation == rgbh_pkg::OP_READ) begin
        rd_addr[c] = bin_of(req.bin_index);
      end else begin
        rd_addr[c] = bin_of(pix[c]);
      end
      if (s1_op == rgbh_pkg::OP_READ) begin
        s1_new[c] = '0;
      end else if (cur[c] == {COUNT_BITS{1'b1}}) begin
        s1_new[c] = cur[c];
      end else begin
        s1_new[c] = cur[c] + COUNT_BITS'(1);
      end
      wr_addr[c] = clearing ? clear_addr : s1_addr[c];
      wr_data[c] = clearing ? '0 : s1_new[c];
    end
  end

  for (genvar c = 0; c < CH; c++) begin : g_ch
    logic [COUNT_BITS-1:0] mem [BIN_COUNT];
    logic [COUNT_BITS-1:0] rdata;

    always_ff @(posedge clk) begin
      if (mem_we) begin
        mem[wr_addr[c]] <= wr_data[c];
      end
      if (accept) begin
        rdata <= mem[rd_addr[c]];
      end
    end

    assign cur[c] = (lw_valid && lw_addr[c] == s1_addr[c]) ? lw_data[c] : rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
      s1_valid   <= 1'b0;
      lw_valid   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (clearing) begin
        if (clear_addr == AW'(BIN_COUNT - 1)) begin
          clearing <= 1'b0;
        end else begin
          clear_addr <= clear_addr + AW'(1);
        end
      end

      if (accept) begin
        s1_valid    <= 1'b1;
        s1_op       <= req.operation;
        s1_in_range <= req_in_range;
        s1_bin      <= req.bin_index;
        s1_addr     <= rd_addr;
        lw_valid    <= s1_we;
        lw_addr     <= s1_addr;
        lw_data     <= s1_new;
      end else begin
        if (s1_fire) begin
          s1_valid <= 1'b0;
        end
        if (mem_we) begin
          lw_valid <= 1'b0;
        end
      end

      if (s1_fire && s1_op == rgbh_pkg::OP_READ) begin
        rsp_valid      <= 1'b1;
        rsp.bin_number <= s1_bin;
        if (s1_in_range) begin
          rsp.red_count   <= rgbh_pkg::OUT_COUNT_BITS'(cur[0]);
          rsp.green_count <= rgbh_pkg::OUT_COUNT_BITS'(cur[1]);
          rsp.blue_count  <= rgbh_pkg::OUT_COUNT_BITS'(cur[2]);
        end else begin
          rsp.red_count   <= '0;
          rsp.green_count <= '0;
          rsp.blue_count  <= '0;
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/rgbh_checker.sv =====
// Port-level checks for the RGB channel histogram and their binding.
`default_nettype none
`include "rgb_channel_histogram_macros.svh"

module rgbh_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire rgbh_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire rgbh_pkg::rsp_t rsp
);

  logic add_taken;

  assign add_taken = req_valid && req_ready && req.operation == rgbh_pkg::OP_ADD;

  `RGBH_ASSERT_NEXT_ALWAYS(a_reset_no_result, clk, rst, !rsp_valid)
  `RGBH_ASSERT_NEXT_ALWAYS(a_reset_clears_first, clk, rst, !req_ready)
  `RGBH_ASSERT_NEXT(a_add_gives_nothing, clk, rst, add_taken ##1 !rsp_valid, !rsp_valid)
  `RGBH_ASSERT_NEXT(a_rsp_held, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `RGBH_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp))

endmodule

bind rgb_channel_histogram rgbh_checker u_rgbh_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);

`default_nettype wire
